FILE: rtl/core/adts_pkg.sv
// Shared types, codes and tables for the ADTS deframer.
package adts_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_EOS     = 2'd2;

  localparam logic [12:0] MAX_PAYLOAD_RESET = 13'd8191;
  localparam logic [12:0] POS_SAT           = 13'd8191;
  localparam logic [19:0] USEC_PER_SEC      = 20'd1000000;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [12:0] payload_size;
    logic [12:0] truncated_bytes;
    logic [1:0]  stream_profile;
    logic [3:0]  rate_index;
    logic [2:0]  channel_count;
    logic [15:0] audio_config;
    logic [17:0] duration_us;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
  } adts_result_t;

  typedef struct packed {
    logic first;   // res0 is pushed
    logic second;  // res1 is pushed behind it
  } adts_push_t;

  // 1024 samples over the sampling rate, in microseconds (truncated)
  function automatic logic [17:0] adts_duration(input logic [3:0] sfi);
    logic [17:0] d;
    case (sfi)
      4'd0:    d = 18'd10666;
      4'd1:    d = 18'd11609;
      4'd2:    d = 18'd16000;
      4'd3:    d = 18'd21333;
      4'd4:    d = 18'd23219;
      4'd5:    d = 18'd32000;
      4'd6:    d = 18'd42666;
      4'd7:    d = 18'd46439;
      4'd8:    d = 18'd64000;
      4'd9:    d = 18'd85333;
      4'd10:   d = 18'd92879;
      4'd11:   d = 18'd128000;
      4'd12:   d = 18'd139319;
      default: d = 18'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/adts_if.sv
// Stream interfaces: input bytes and result records.
interface adts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, data_byte, buffer_last, input ready);
  modport sink   (input valid, data_byte, buffer_last, output ready);
endinterface

interface adts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [12:0] payload_size;
  logic [12:0] truncated_bytes;
  logic [1:0]  stream_profile;
  logic [3:0]  rate_index;
  logic [2:0]  channel_count;
  logic [15:0] audio_config;
  logic [17:0] duration_us;
  logic [31:0] time_sec;
  logic [19:0] time_usec;

  modport source (output valid, kind, payload_byte, payload_size, truncated_bytes,
                  stream_profile, rate_index, channel_count, audio_config,
                  duration_us, time_sec, time_usec, input ready);
  modport sink   (input valid, kind, payload_byte, payload_size, truncated_bytes,
                  stream_profile, rate_index, channel_count, audio_config,
                  duration_us, time_sec, time_usec, output ready);
endinterface

FILE: rtl/core/adts_parse.sv
// Input register, header decode, stream capture, payload gating and frame records.
module adts_parse (
  input  logic                  clk,
  input  logic                  rst,
  adts_in_if.sink               frame,
  input  logic [12:0]           max_payload,
  input  logic                  room2,
  output adts_pkg::adts_push_t  push,
  output adts_pkg::adts_result_t res0,
  output adts_pkg::adts_result_t res1
);
  import adts_pkg::*;

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;

  // per-buffer state
  logic [12:0] pos;
  logic [7:0]  hdr [6];
  logic [12:0] decl;
  logic        crc;

  // stream state
  logic        captured;
  logic [1:0]  prof;
  logic [3:0]  sfi;
  logic [2:0]  chcfg;
  logic [15:0] acfg;
  logic [17:0] dur;
  logic [31:0] csec;
  logic [19:0] cusec;
  logic        started;

  logic        go;
  logic        at6;
  logic [1:0]  prof_h;
  logic [3:0]  sfi_h;
  logic [2:0]  ch_h;
  logic        crc_h;
  logic        hdr_ok;
  logic        cap_now;
  logic [12:0] flen;
  logic [12:0] pay7;
  logic [12:0] pay;
  logic [12:0] decl_eff;
  logic        crc_eff;
  logic [12:0] cap;
  logic [12:0] off;
  logic [12:0] rel;
  logic        emit;
  logic [15:0] acfg_h;
  logic [17:0] dur_h;
  logic [1:0]  prof_eff;
  logic [3:0]  sfi_eff;
  logic [2:0]  ch_eff;
  logic [15:0] acfg_eff;
  logic [17:0] dur_eff;
  logic [20:0] us_sum;
  logic        us_wrap;
  logic [31:0] csec_next;
  logic [19:0] cusec_next;
  adts_result_t rec;
  adts_result_t pl;

  assign go          = s_valid && room2;
  assign frame.ready = !s_valid || room2;

  assign at6    = (pos == 13'd6);
  assign prof_h = hdr[2][7:6];
  assign sfi_h  = hdr[2][5:2];
  assign ch_h   = {hdr[2][0], hdr[3][7:6]};
  assign crc_h  = !hdr[1][0];
  assign hdr_ok = (hdr[0] == 8'hFF) && (hdr[1][7:4] == 4'hF) && (prof_h != 2'd3)
                  && (sfi_h < 4'd13);
  assign cap_now = at6 && !captured && hdr_ok;

  assign flen = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
  assign pay7 = (flen > 13'd7) ? flen - 13'd7 : 13'd0;
  assign pay  = crc_h ? ((pay7 > 13'd2) ? pay7 - 13'd2 : 13'd0) : pay7;

  // the header is decoded on the byte right after it, so use fresh values there
  assign decl_eff = at6 ? pay : decl;
  assign crc_eff  = at6 ? crc_h : crc;
  assign cap      = (decl_eff < max_payload) ? decl_eff : max_payload;
  assign off      = crc_eff ? 13'd9 : 13'd7;
  assign rel      = pos - off;
  assign emit     = (pos >= 13'd7) && (pos >= off) && (rel < cap);

  assign acfg_h   = {3'b000, prof_h + 2'd1, sfi_h[3:1], sfi_h[0], 1'b0, ch_h, 3'b000};
  assign dur_h    = adts_duration(sfi_h);
  assign prof_eff = cap_now ? prof_h : prof;
  assign sfi_eff  = cap_now ? sfi_h : sfi;
  assign ch_eff   = cap_now ? ch_h : chcfg;
  assign acfg_eff = cap_now ? acfg_h : acfg;
  assign dur_eff  = cap_now ? dur_h : dur;

  // duration is under one second, so at most one carry into seconds
  assign us_sum  = {1'b0, cusec} + {3'b000, dur_eff};
  assign us_wrap = (us_sum >= {1'b0, USEC_PER_SEC});
  always_comb begin
    if (!started) begin
      csec_next  = '0;
      cusec_next = '0;
    end else if (us_wrap) begin
      csec_next  = csec + 32'd1;
      cusec_next = 20'(us_sum - {1'b0, USEC_PER_SEC});
    end else begin
      csec_next  = csec;
      cusec_next = us_sum[19:0];
    end
  end

  always_comb begin
    rec = '0;
    if (pos < 13'd6) begin
      rec.kind = KIND_EOS;
    end else begin
      rec.kind            = KIND_DONE;
      rec.payload_size    = cap;
      rec.truncated_bytes = decl_eff - cap;
      rec.stream_profile  = prof_eff;
      rec.rate_index      = sfi_eff;
      rec.channel_count   = (ch_eff == 3'd0) ? 3'd2 : ch_eff;
      rec.audio_config    = acfg_eff;
      rec.duration_us     = dur_eff;
      rec.time_sec        = csec_next;
      rec.time_usec       = cusec_next;
    end
  end

  always_comb begin
    pl              = '0;
    pl.kind         = KIND_PAYLOAD;
    pl.payload_byte = s_byte;
  end

  assign res0        = emit ? pl : rec;
  assign res1        = rec;
  assign push.first  = go && (emit || s_last);
  assign push.second = go && emit && s_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid  <= 1'b0;
      pos      <= '0;
      decl     <= '0;
      crc      <= 1'b0;
      captured <= 1'b0;
      prof     <= 2'd3;
      sfi      <= '0;
      chcfg    <= '0;
      acfg     <= '0;
      dur      <= '0;
      csec     <= '0;
      cusec    <= '0;
      started  <= 1'b0;
    end else begin
      if (frame.ready) begin
        s_valid <= frame.valid;
      end
      if (go) begin
        if (pos < 13'd6) begin
          hdr[pos[2:0]] <= s_byte;
        end
        if (cap_now) begin
          captured <= 1'b1;
          prof     <= prof_h;
          sfi      <= sfi_h;
          chcfg    <= ch_h;
          acfg     <= acfg_h;
          dur      <= dur_h;
        end
        if (s_last) begin
          pos  <= '0;
          decl <= '0;
          crc  <= 1'b0;
          if (pos >= 13'd6) begin
            started <= 1'b1;
            csec    <= csec_next;
            cusec   <= cusec_next;
          end
        end else begin
          if (at6) begin
            decl <= pay;
            crc  <= crc_h;
          end
          if (pos != POS_SAT) begin
            pos <= pos + 13'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s_byte <= frame.data_byte;
      s_last <= frame.buffer_last;
    end
  end

  a_last_gives_record: assert property (@(posedge clk) disable iff (rst)
    (go && s_last) |-> push.first)
    else $error("last byte of a buffer produced no record");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> (res0.kind == KIND_PAYLOAD && res1.kind == KIND_DONE))
    else $error("paired results out of order");

  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    (go && s_last) |=> (pos == 13'd0))
    else $error("byte position not cleared after buffer end");

endmodule

FILE: rtl/core/adts_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
module adts_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  adts_pkg::adts_push_t   push,
  input  adts_pkg::adts_result_t res0,
  input  adts_pkg::adts_result_t res1,
  output logic                   room2,
  adts_out_if.source             result
);
  import adts_pkg::*;

  adts_result_t     mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wp;
  logic [RQ_AW-1:0] rp;
  logic [RQ_CW-1:0] count;
  logic [RQ_CW-1:0] count_next;
  logic             pop;
  adts_result_t     head;

  assign room2 = (count <= RQ_CW'(RQ_DEPTH - 2));
  assign pop   = result.valid && result.ready;
  assign head  = mem[rp];

  assign count_next = count + RQ_CW'(push.first) + RQ_CW'(push.second) - RQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push.second) begin
        wp <= wp + RQ_AW'(2);
      end else if (push.first) begin
        wp <= wp + RQ_AW'(1);
      end
      if (pop) begin
        rp <= rp + RQ_AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wp] <= res0;
    end
    if (push.second) begin
      mem[wp + RQ_AW'(1)] <= res1;
    end
  end

  assign result.valid           = (count != '0);
  assign result.kind            = head.kind;
  assign result.payload_byte    = head.payload_byte;
  assign result.payload_size    = head.payload_size;
  assign result.truncated_bytes = head.truncated_bytes;
  assign result.stream_profile  = head.stream_profile;
  assign result.rate_index      = head.rate_index;
  assign result.channel_count   = head.channel_count;
  assign result.audio_config    = head.audio_config;
  assign result.duration_us     = head.duration_us;
  assign result.time_sec        = head.time_sec;
  assign result.time_usec       = head.time_usec;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second push without first");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push.first && count == '0) |=> result.valid)
    else $error("pushed result not presented");

endmodule

FILE: rtl/core/adts_frame_deframer_core.sv
// Top level of the ADTS frame deframer: config register and datapath.
// Takes one byte per clock on frame and delivers payload bytes, frame-done and
// end-of-stream records on result. A byte passes an input register, is decoded
// and its results enter a four-entry result queue; a result is valid once pushed
// there and can leave at the following edge. Sustained rate is one byte per
// cycle while the queue has room; a frame-ending byte that also carries a payload
// byte yields two results, which leave one after the other; frame.ready goes low
// only while the input register holds a byte and the queue has fewer than two
// free entries. max_payload (reset 8191) is written through cfg_we/cfg_data; the
// user must write it only while no request is in flight; the block won't check.
module adts_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  adts_in_if.sink     frame,
  adts_out_if.source  result
);
  import adts_pkg::*;

  logic [12:0]  max_payload;
  logic         room2;
  adts_push_t   push;
  adts_result_t res0;
  adts_result_t res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_data;
    end
  end

  adts_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .max_payload (max_payload),
    .room2       (room2),
    .push        (push),
    .res0        (res0),
    .res1        (res1)
  );

  adts_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .res0   (res0),
    .res1   (res1),
    .room2  (room2),
    .result (result)
  );

endmodule

FILE: dv/adts_frame_deframer_core_tb.sv
// Self-checking testbench for the ADTS frame deframer: directed table, then random buffers.
module adts_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adts_pkg::*;

  localparam int LIMIT          = 1000000;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_TAIL      = 8;
  localparam int PHASE_BYTES    = 300;
  localparam int SAMPLES_X_USEC = 1024 * 1000000;
  localparam int DIR_N          = 27;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    adts_result_t want;
  } row_t;

  localparam adts_result_t NO_REC  = '0;
  localparam adts_result_t EOS_REC = '{kind: KIND_EOS, default: '0};
  // frame done before any stream settings are captured
  localparam adts_result_t BLANK_DONE =
    '{kind: KIND_DONE, stream_profile: 2'd3, channel_count: 3'd2, default: '0};

  localparam row_t DIR_ROWS [DIR_N] = '{
    // six-byte buffer: one short of a header
    '{8'h00, 1'b0, 1'b0, NO_REC}, '{8'hFF, 1'b0, 1'b0, NO_REC},
    '{8'h12, 1'b0, 1'b0, NO_REC}, '{8'h34, 1'b0, 1'b0, NO_REC},
    '{8'h56, 1'b0, 1'b0, NO_REC}, '{8'h78, 1'b1, 1'b1, EOS_REC},
    // bad syncword in the second byte
    '{8'hFF, 1'b0, 1'b0, NO_REC}, '{8'h01, 1'b0, 1'b0, NO_REC},
    '{8'h50, 1'b0, 1'b0, NO_REC}, '{8'h80, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC}, '{8'h1F, 1'b0, 1'b0, NO_REC},
    '{8'hAA, 1'b1, 1'b1, BLANK_DONE},
    // reserved profile
    '{8'hFF, 1'b0, 1'b0, NO_REC}, '{8'hF1, 1'b0, 1'b0, NO_REC},
    '{8'hD0, 1'b0, 1'b0, NO_REC}, '{8'h40, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC}, '{8'h00, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b1, 1'b1, BLANK_DONE},
    // reserved rate index, CRC present, zero frame length
    '{8'hFF, 1'b0, 1'b0, NO_REC}, '{8'hF0, 1'b0, 1'b0, NO_REC},
    '{8'h74, 1'b0, 1'b0, NO_REC}, '{8'hC0, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC}, '{8'h1F, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b1, 1'b1, BLANK_DONE}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [12:0] cfg_data;

  adts_in_if  frame_if ();
  adts_out_if result_if ();

  adts_frame_deframer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .frame    (frame_if),
    .result   (result_if)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // deframer state as the block should hold it
  logic [12:0] max_pl;
  logic [12:0] pos_q;
  logic [47:0] hdr_q;
  logic [12:0] decl_q;
  logic        crc_q;
  logic        capd_q;
  logic [1:0]  prof_q;
  logic [3:0]  sfi_q;
  logic [2:0]  ch_q;
  logic [15:0] asc_q;
  logic [17:0] dur_q;
  logic [31:0] pts_sec_q;
  logic [19:0] pts_usec_q;
  logic        started_q;

  adts_result_t pending_records [$];
  int           mismatches;
  int           bytes_sent;
  int           burst_left;

  function automatic int sample_rate_hz(input logic [3:0] sfi);
    case (sfi)
      4'd0:    return 96000;
      4'd1:    return 88200;
      4'd2:    return 64000;
      4'd3:    return 48000;
      4'd4:    return 44100;
      4'd5:    return 32000;
      4'd6:    return 24000;
      4'd7:    return 22050;
      4'd8:    return 16000;
      4'd9:    return 12000;
      4'd10:   return 11025;
      4'd11:   return 8000;
      4'd12:   return 7350;
      default: return 0;
    endcase
  endfunction

  function automatic void parse_header();
    logic [7:0] h0, h1, h2, h3, h4, h5;
    logic [1:0] prof;
    logic [3:0] sfi;
    logic [2:0] ch;
    int         rate, flen, pay;
    h0   = hdr_q[7:0];
    h1   = hdr_q[15:8];
    h2   = hdr_q[23:16];
    h3   = hdr_q[31:24];
    h4   = hdr_q[39:32];
    h5   = hdr_q[47:40];
    prof = h2[7:6];
    sfi  = h2[5:2];
    ch   = {h2[0], h3[7:6]};
    rate = sample_rate_hz(sfi);
    if (!capd_q && h0 == 8'hFF && h1[7:4] == 4'hF && prof != 2'd3 && rate != 0) begin
      capd_q = 1'b1;
      prof_q = prof;
      sfi_q  = sfi;
      ch_q   = ch;
      asc_q  = {3'b000, 2'(prof + 2'd1), sfi[3:1], sfi[0], 1'b0, ch, 3'b000};
      dur_q  = 18'(SAMPLES_X_USEC / rate);
    end
    crc_q = ~h1[0];
    flen  = int'({h3[1:0], h4, h5[7:5]});
    pay   = (flen > 7) ? flen - 7 : 0;
    if (crc_q) pay = (pay > 2) ? pay - 2 : 0;
    decl_q = 13'(pay);
  endfunction

  // Advance the deframer by one accepted byte and queue what it should emit.
  task automatic deframe_byte(input logic [7:0] b, input logic last, input logic typed,
                              input adts_result_t want);
    int           idx, cap, off, us;
    adts_result_t rec;
    idx = int'(pos_q);
    cap = (decl_q < max_pl) ? int'(decl_q) : int'(max_pl);
    off = crc_q ? 9 : 7;
    if (idx < 6) hdr_q[8*idx +: 8] = b;
    if (idx == 6) begin
      parse_header();
      cap = (decl_q < max_pl) ? int'(decl_q) : int'(max_pl);
      off = crc_q ? 9 : 7;
    end
    if (idx >= 7 && idx >= off && idx - off < cap) begin
      rec              = '0;
      rec.kind         = KIND_PAYLOAD;
      rec.payload_byte = b;
      pending_records.push_back(rec);
    end
    if (pos_q < POS_SAT) pos_q = pos_q + 13'd1;
    if (last) begin
      rec = '0;
      if (idx < 6) begin
        rec.kind = KIND_EOS;
      end else begin
        if (!started_q) begin
          started_q  = 1'b1;
          pts_sec_q  = '0;
          pts_usec_q = '0;
        end else begin
          us         = int'(pts_usec_q) + int'(dur_q);
          pts_sec_q  = pts_sec_q + 32'(us / int'(USEC_PER_SEC));
          pts_usec_q = 20'(us % int'(USEC_PER_SEC));
        end
        rec.kind            = KIND_DONE;
        rec.payload_size    = 13'(cap);
        rec.truncated_bytes = decl_q - 13'(cap);
        rec.stream_profile  = prof_q;
        rec.rate_index      = sfi_q;
        rec.channel_count   = (ch_q == 3'd0) ? 3'd2 : ch_q;
        rec.audio_config    = asc_q;
        rec.duration_us     = dur_q;
        rec.time_sec        = pts_sec_q;
        rec.time_usec       = pts_usec_q;
      end
      if (typed) rec = want;
      pending_records.push_back(rec);
      pos_q  = '0;
      hdr_q  = '0;
      decl_q = '0;
      crc_q  = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_record(input adts_result_t got);
    adts_result_t want;
    if (pending_records.size() == 0) begin
      $error("unexpected result, kind %0d", got.kind);
      mismatches++;
      return;
    end
    want = pending_records.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("payload_byte", want.payload_byte, got.payload_byte);
    check_field("payload_size", want.payload_size, got.payload_size);
    check_field("truncated_bytes", want.truncated_bytes, got.truncated_bytes);
    check_field("stream_profile", want.stream_profile, got.stream_profile);
    check_field("rate_index", want.rate_index, got.rate_index);
    check_field("channel_count", want.channel_count, got.channel_count);
    check_field("audio_config", want.audio_config, got.audio_config);
    check_field("duration_us", want.duration_us, got.duration_us);
    check_field("time_sec", want.time_sec, got.time_sec);
    check_field("time_usec", want.time_usec, got.time_usec);
  endtask

  // Outputs are stable from the falling edge to the next rising edge.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && result_if.valid === 1'b1 && result_if.ready) begin
        check_record('{kind: result_if.kind, payload_byte: result_if.payload_byte,
                       payload_size: result_if.payload_size,
                       truncated_bytes: result_if.truncated_bytes,
                       stream_profile: result_if.stream_profile,
                       rate_index: result_if.rate_index,
                       channel_count: result_if.channel_count,
                       audio_config: result_if.audio_config,
                       duration_us: result_if.duration_us,
                       time_sec: result_if.time_sec, time_usec: result_if.time_usec});
      end
    end
  end

  // receiver: runs of ready, short stalls, now and then a long clean run
  initial begin
    result_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      result_if.ready <= 1'b1;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 30))
        @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // sender: bursts of requests with random gaps between them
  task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                           input adts_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        frame_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    frame_if.valid       <= 1'b1;
    frame_if.data_byte   <= b;
    frame_if.buffer_last <= last;
    do @(negedge clk); while (!frame_if.ready);
    deframe_byte(b, last, typed, want);
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    frame_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [12:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_pl = v;
  endtask

  task automatic send_frame(input logic [7:0] sync0, input logic [3:0] sync1,
                            input logic [1:0] prof, input logic [3:0] sfi,
                            input logic [2:0] ch, input logic prot,
                            input int flen, input int blen);
    logic [12:0] fl;
    logic [7:0]  b;
    fl = 13'(flen);
    for (int i = 0; i < blen; i++) begin
      case (i)
        0:       b = sync0;
        1:       b = {sync1, 3'($urandom), prot};
        2:       b = {prof, sfi, 1'($urandom), ch[2]};
        3:       b = {ch[1:0], 4'($urandom), fl[12:11]};
        4:       b = fl[10:3];
        5:       b = {fl[2:0], 5'($urandom)};
        default: b = 8'($urandom);
      endcase
      send_item(b, i == blen - 1, 1'b0, NO_REC);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_item(8'($urandom), i == n - 1, 1'b0, NO_REC);
  endtask

  task automatic random_buffer();
    int         r, flen, blen;
    logic [7:0] s0;
    logic [3:0] s1;
    logic [1:0] prof;
    logic [3:0] sfi;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      s0   = 8'hFF;
      s1   = 4'hF;
      prof = 2'($urandom_range(0, 2));
      sfi  = 4'($urandom_range(0, 12));
      if (r >= 78) begin
        case ($urandom_range(0, 3))
          0:       s0 = 8'($urandom_range(0, 254));
          1:       s1 = 4'($urandom_range(0, 14));
          2:       prof = 2'd3;
          default: sfi = 4'($urandom_range(13, 15));
        endcase
      end
      r = $urandom_range(0, 19);
      if (r < 2) flen = $urandom_range(0, 10);
      else if (r == 2) flen = $urandom_range(100, 8191);
      else flen = $urandom_range(7, 48);
      r = $urandom_range(0, 9);
      // long declared frames are cut short to keep the run small
      if (flen >= 100) blen = $urandom_range(7, 64);
      else if (r == 0) blen = $urandom_range(1, (flen > 1) ? flen - 1 : 1);
      else if (r == 1) blen = flen + $urandom_range(1, 4);
      else blen = (flen < 1) ? 1 : flen;
      send_frame(s0, s1, prof, sfi, 3'($urandom_range(0, 7)), 1'($urandom), flen, blen);
    end else if (r < 94) begin
      send_noise($urandom_range(7, 24));
    end else begin
      send_noise($urandom_range(1, 6));
    end
  endtask

  task automatic run_phase(input logic [12:0] cap);
    int start;
    set_max_payload(cap);
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_buffer();
    drain();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    frame_if.valid       = 1'b0;
    frame_if.data_byte   = '0;
    frame_if.buffer_last = 1'b0;
    mismatches           = 0;
    bytes_sent           = 0;
    burst_left           = 0;
    max_pl               = MAX_PAYLOAD_RESET;
    pos_q                = '0;
    hdr_q                = '0;
    decl_q               = '0;
    crc_q                = 1'b0;
    capd_q               = 1'b0;
    prof_q               = 2'd3;
    sfi_q                = '0;
    ch_q                 = '0;
    asc_q                = '0;
    dur_q                = '0;
    pts_sec_q            = '0;
    pts_usec_q           = '0;
    started_q            = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    set_max_payload(MAX_PAYLOAD_RESET);
    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain();

    run_phase(MAX_PAYLOAD_RESET);
    run_phase(13'd0);
    run_phase(13'd1);
    run_phase(13'($urandom_range(2, 24)));
    run_phase(13'($urandom_range(0, 8191)));
    run_phase(MAX_PAYLOAD_RESET);

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/adts_pkg.sv
rtl/core/adts_if.sv
rtl/core/adts_parse.sv
rtl/core/adts_fifo.sv
rtl/core/adts_frame_deframer_core.sv
dv/adts_frame_deframer_core_tb.sv
